### design/ptbl_pkg.sv
// ----------------------------------------------------------------------------
// ptbl_pkg: shared types and constants of the per-client token bucket limiter
// Widths, register indexes, reset values, controller states and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ptbl_pkg;

  localparam int CLIENTS = 64;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int TOK_W   = 16;
  localparam int TIME_W  = 32;
  localparam int PROD_W  = TIME_W + TOK_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [TOK_W-1:0] CAPACITY_RESET = 16'd100;
  localparam logic [TOK_W-1:0] REFILL_RESET   = 16'd10;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_PER_SECOND = 8'd1;

  typedef struct packed {
    logic [TOK_W-1:0]  tokens;
    logic [TOK_W-1:0]  capacity;
    logic [TIME_W-1:0] last_time;
  } slot_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_SAT,
    S_DEC
  } state_t;

  typedef struct packed {
    logic load_in;
    logic capture;
    logic mul;
    logic sat;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

### design/ptbl_if.sv
// ----------------------------------------------------------------------------
// ptbl_if: channel interfaces of the token bucket limiter
// Request, response and configuration write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface ptbl_req_if;
  logic                         valid;
  logic                         ready;
  logic [ptbl_pkg::SLOT_W-1:0]  client_slot;
  logic [ptbl_pkg::TOK_W-1:0]   cost;
  logic [ptbl_pkg::TIME_W-1:0]  now_seconds;

  modport source (output valid, client_slot, cost, now_seconds, input ready);
  modport sink   (input valid, client_slot, cost, now_seconds, output ready);
endinterface

interface ptbl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        allowed;
  logic [ptbl_pkg::TOK_W-1:0]  tokens_left;

  modport source (output valid, allowed, tokens_left, input ready);
  modport sink   (input valid, allowed, tokens_left, output ready);
endinterface

interface ptbl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ptbl_pkg::CFG_IDX_W-1:0] index;
  logic [ptbl_pkg::TOK_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/ptbl_ctrl.sv
// ----------------------------------------------------------------------------
// ptbl_ctrl: request sequencer
// Walks one request through read, multiply, saturate and decide, and holds
// the decide step until the output register can take the result.
// ----------------------------------------------------------------------------
module ptbl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ptbl_pkg::dp_status_t status,
  output ptbl_pkg::dp_cmd_t    cmd
);

  ptbl_pkg::state_t state;
  ptbl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptbl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd         = '0;
    case (state)
      ptbl_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ptbl_pkg::S_READ;
        end
      end
      ptbl_pkg::S_READ: begin
        cmd.capture = 1'b1;
        state_next  = ptbl_pkg::S_MUL;
      end
      ptbl_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ptbl_pkg::S_SAT;
      end
      ptbl_pkg::S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = ptbl_pkg::S_DEC;
      end
      ptbl_pkg::S_DEC: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ptbl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptbl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/ptbl_dp.sv
// ----------------------------------------------------------------------------
// ptbl_dp: token bucket datapath
// Slot table, configuration registers, refill multiply and saturation,
// cost check and the output register.
// ----------------------------------------------------------------------------
module ptbl_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  ptbl_pkg::dp_cmd_t              cmd,
  output ptbl_pkg::dp_status_t           status,
  input  logic [ptbl_pkg::SLOT_W-1:0]    client_slot,
  input  logic [ptbl_pkg::TOK_W-1:0]     cost,
  input  logic [ptbl_pkg::TIME_W-1:0]    now_seconds,
  input  logic                           cfg_we,
  input  logic [ptbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptbl_pkg::TOK_W-1:0]     cfg_data,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           rsp_allowed,
  output logic [ptbl_pkg::TOK_W-1:0]     rsp_tokens_left
);

  localparam int WIDE_W = ptbl_pkg::SLOT_W + ptbl_pkg::IDX_W;

  logic [ptbl_pkg::TOK_W-1:0]  bucket_capacity;
  logic [ptbl_pkg::TOK_W-1:0]  refill_per_second;

  ptbl_pkg::slot_entry_t       mem [ptbl_pkg::CLIENTS];
  logic [ptbl_pkg::CLIENTS-1:0] slot_valid;

  logic [WIDE_W-1:0]           slot_wide;
  logic [ptbl_pkg::IDX_W-1:0]  req_addr;
  logic                        req_bad;

  logic [ptbl_pkg::IDX_W-1:0]  addr;
  logic                        bad;
  logic [ptbl_pkg::TOK_W-1:0]  in_cost;
  logic [ptbl_pkg::TIME_W-1:0] in_now;
  ptbl_pkg::slot_entry_t       rd_data;
  logic                        rd_hit;

  logic [ptbl_pkg::TOK_W-1:0]  cur_tokens;
  logic [ptbl_pkg::TOK_W-1:0]  cur_cap;
  logic [ptbl_pkg::TIME_W-1:0] elapsed;
  logic [ptbl_pkg::PROD_W-1:0] prod;
  logic [ptbl_pkg::TOK_W-1:0]  level;

  logic [ptbl_pkg::PROD_W:0]   sum;
  logic [ptbl_pkg::TOK_W-1:0]  level_next;
  logic                        pass;
  logic [ptbl_pkg::TOK_W-1:0]  tokens_next;

  assign slot_wide = {{ptbl_pkg::IDX_W{1'b0}}, client_slot};
  assign req_addr  = slot_wide[ptbl_pkg::IDX_W-1:0];
  assign req_bad   = slot_wide >= WIDE_W'(ptbl_pkg::CLIENTS);

  assign status.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity   <= ptbl_pkg::CAPACITY_RESET;
      refill_per_second <= ptbl_pkg::REFILL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ptbl_pkg::REG_BUCKET_CAPACITY:   bucket_capacity   <= cfg_data;
        ptbl_pkg::REG_REFILL_PER_SECOND: refill_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture and registered table read.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr    <= req_addr;
      bad     <= req_bad;
      in_cost <= cost;
      in_now  <= now_seconds;
      rd_data <= mem[req_addr];
      rd_hit  <= slot_valid[req_addr];
    end
  end

  // A slot seen for the first time starts full, stamped with this request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (rd_hit) begin
        cur_tokens <= rd_data.tokens;
        cur_cap    <= rd_data.capacity;
        elapsed    <= in_now - rd_data.last_time;
      end else begin
        cur_tokens <= bucket_capacity;
        cur_cap    <= bucket_capacity;
        elapsed    <= '0;
      end
    end
    if (cmd.mul) begin
      prod <= ptbl_pkg::PROD_W'(elapsed) * ptbl_pkg::PROD_W'(refill_per_second);
    end
    if (cmd.sat) begin
      level <= level_next;
    end
  end

  always_comb begin
    sum = {1'b0, prod} + {{(ptbl_pkg::PROD_W + 1 - ptbl_pkg::TOK_W){1'b0}}, cur_tokens};
    if (sum > {{(ptbl_pkg::PROD_W + 1 - ptbl_pkg::TOK_W){1'b0}}, cur_cap}) begin
      level_next = cur_cap;
    end else begin
      level_next = sum[ptbl_pkg::TOK_W-1:0];
    end
    pass        = level >= in_cost;
    tokens_next = pass ? level - in_cost : level;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !bad) begin
      mem[addr] <= '{tokens: tokens_next, capacity: cur_cap, last_time: in_now};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit && !bad) begin
      slot_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_allowed     <= pass && !bad;
      rsp_tokens_left <= bad ? '0 : tokens_next;
    end
  end

endmodule

### design/per_client_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter: per-client token bucket rate limiter
// A request names a client slot, a cost and the time in seconds; the slot's
// bucket is refilled by elapsed time and charged if it holds enough tokens.
//
// Channels: req takes one transaction per request, rsp returns one
// transaction per request in order, cfg writes bucket_capacity (index 0) or
// refill_per_second (index 1); other indexes are ignored. cfg is always ready
// and the user must see that it is written only while no request is in
// flight; the block itself does not enforce this. The sequencer steps
// through the table read, the refill multiply, the saturation add and the
// decision, one request at a time, and takes a new request only after the
// decision of the last one has been registered in the output register.
// Reset: configuration returns to 100 and 10 and every slot is marked unused
// at once; the table contents themselves are not cleared.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, and the decision step holds until the register frees.
// ----------------------------------------------------------------------------
module per_client_token_bucket_limiter (
  input  logic       clk,
  input  logic       rst,
  ptbl_req_if.sink   req,
  ptbl_rsp_if.source rsp,
  ptbl_cfg_if.sink   cfg
);

  ptbl_pkg::dp_cmd_t    cmd;
  ptbl_pkg::dp_status_t status;

  assign cfg.ready = 1'b1;

  ptbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ptbl_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .client_slot     (req.client_slot),
    .cost            (req.cost),
    .now_seconds     (req.now_seconds),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_allowed     (rsp.allowed),
    .rsp_tokens_left (rsp.tokens_left)
  );

endmodule

### design/ptbl_checker.sv
// ----------------------------------------------------------------------------
// ptbl_checker: port-level checks of the token bucket limiter
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module ptbl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_allowed,
  input logic [ptbl_pkg::TOK_W-1:0] rsp_tokens_left
);

  // A stalled result keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allowed) && $stable(rsp_tokens_left))
    else $error("response changed while stalled");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  // Every accepted request is followed by a valid response.
  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##5 rsp_valid)
    else $error("no response after an accepted request");

endmodule

bind per_client_token_bucket_limiter ptbl_checker u_ptbl_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_allowed     (rsp.allowed),
  .rsp_tokens_left (rsp.tokens_left)
);
